// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the contact table RTL.
// No dependencies; compiled out when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSDR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define CSDR_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);
`else
`define CSDR_ASSERT(lbl, clk, rstn, prop, msg)
`define CSDR_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// ===== hdl/csdr_pkg.sv =====
// Types and constants for the contact point table.
// No dependencies; imported by csdr_cmp and contact_set_dedup_replace.
`timescale 1ns / 1ps

package csdr_pkg;

    localparam int S_DATA_W = 200;
    localparam int M_DATA_W = 208;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_EPSILON   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_EPSILON = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RESULT
    } state_t;

    // px in the lowest bits, matching the input beat layout
    typedef struct packed {
        logic signed [16:0] side;
        logic signed [15:0] nz;
        logic signed [15:0] ny;
        logic signed [15:0] nx;
        logic [30:0]        depth;
        logic signed [31:0] pz;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } entry_t;

    typedef struct packed {
        logic match;
        logic deeper;
        logic shallower;
        logic below_min;
    } cmp_res_t;

endpackage

// ===== hdl/contact_set_dedup_replace.sv =====
// Contact point table with duplicate suppression and shallowest-entry replacement.
// Depends on csdr_pkg, csdr_cmp and assert_macros.svh.
//
// One command per input beat: clear, offer, read or no operation, each giving one
// result beat. An offer walks the stored entries one per cycle through a single
// compare unit fed from the registered read port of the entry memory, stepping
// through accept, scan and write, with a matching entry ending the scan early;
// clear, read and no operation go from accept to result. A result held downstream
// stalls the write or result step. The input is accepted only while the sequencer
// is idle, in the cycle after the previous result is loaded; a result waiting
// downstream does not block acceptance. Configuration writes are always taken and
// should be made while the table is idle. Entries are undefined until written;
// reads beyond the count return zeros.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module contact_set_dedup_replace #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: pos_x, pos_y, pos_z, depth, normal_x, normal_y, normal_z, side,
    //          read_index
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [csdr_pkg::S_DATA_W-1:0]        s_tdata,
    // s_tuser: command
    input  logic [1:0]                           s_tuser,
    // m_tdata: slot, count, out_pos_x, out_pos_y, out_pos_z, read_depth,
    //          out_normal_x, out_normal_y, out_normal_z, out_side
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [csdr_pkg::M_DATA_W-1:0]        m_tdata,
    // m_tuser: accepted
    output logic [0:0]                           m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [csdr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csdr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import csdr_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    entry_t          new_reg, new_next;
    logic [3:0]      rd_index_reg, rd_index_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   scan_idx_reg, scan_idx_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            have_min_reg, have_min_next;
    logic [30:0]     min_depth_reg, min_depth_next;
    logic [4:0]      slot_limit_reg;
    logic [15:0]     pos_eps_reg, depth_eps_reg;

    entry_t          mem [MAX_ENTRIES];
    entry_t          rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    logic            in_acc, out_free, load_out;
    cmd_t            s_cmd;
    entry_t          s_entry;
    logic [CW-1:0]   limit;
    logic            full, scan_last, read_hit;
    cmp_res_t        cmp_res;
    logic            res_acc;
    logic [3:0]      res_slot;
    entry_t          res_entry;

    assign s_cmd    = cmd_t'(s_tuser);
    assign s_entry  = entry_t'(s_tdata[$bits(entry_t)-1:0]);
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (slot_limit_reg == 5'd0) begin
            limit = CW'(1);
        end else if (int'(slot_limit_reg) > MAX_ENTRIES) begin
            limit = CW'(MAX_ENTRIES);
        end else begin
            limit = CW'(slot_limit_reg);
        end
    end

    assign full      = (count_reg == limit);
    assign scan_last = (scan_idx_reg == count_reg - 1'b1);
    assign read_hit  = int'(rd_index_reg) < int'(count_reg);

    csdr_cmp u_cmp (
        .new_entry (new_reg),
        .stored    (rd_data_reg),
        .pos_eps   (pos_eps_reg),
        .depth_eps (depth_eps_reg),
        .min_depth (min_depth_reg),
        .res       (cmp_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_cmd == CMD_OFFER) begin
                        state_next = (count_reg == '0) ? S_WRITE : S_SCAN;
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_SCAN: begin
                if (cmp_res.match || scan_last) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE, S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd_next       = cmd_reg;
        new_next       = new_reg;
        rd_index_next  = rd_index_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        idx_next       = idx_reg;
        have_min_next  = have_min_reg;
        min_depth_next = min_depth_reg;
        rd_addr        = '0;
        mem_we         = 1'b0;
        load_out       = 1'b0;
        res_acc        = 1'b0;
        res_slot       = 4'd0;
        res_entry      = '0;
        case (state_reg)
            S_IDLE: begin
                rd_addr = (s_cmd == CMD_READ) ? AW'(s_tdata[195:192]) : '0;
                if (in_acc) begin
                    cmd_next      = s_cmd;
                    new_next      = s_entry;
                    rd_index_next = s_tdata[195:192];
                    scan_idx_next = '0;
                    idx_next      = count_reg;
                    have_min_next = 1'b0;
                end
            end
            S_SCAN: begin
                rd_addr = AW'(scan_idx_reg + 1'b1);
                if (cmp_res.match) begin
                    idx_next = cmp_res.deeper ? scan_idx_reg : limit;
                end else begin
                    if (full && (!have_min_reg || cmp_res.below_min) && cmp_res.shallower) begin
                        have_min_next  = 1'b1;
                        min_depth_next = rd_data_reg.depth;
                        idx_next       = scan_idx_reg;
                    end
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (idx_reg < limit) begin
                        mem_we   = 1'b1;
                        res_acc  = 1'b1;
                        res_slot = 4'(idx_reg);
                        if (idx_reg == count_reg) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            S_RESULT: begin
                rd_addr = AW'(rd_index_reg);
                if (out_free) begin
                    load_out = 1'b1;
                    case (cmd_reg)
                        CMD_CLEAR: count_next = '0;
                        CMD_READ: begin
                            res_slot = rd_index_reg;
                            if (read_hit) begin
                                res_entry = rd_data_reg;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            slot_limit_reg <= 5'd16;
            pos_eps_reg    <= 16'd7;
            depth_eps_reg  <= 16'd7;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SLOT_LIMIT:    slot_limit_reg <= cfg_data[4:0];
                    CFG_POS_EPSILON:   pos_eps_reg    <= cfg_data;
                    CFG_DEPTH_EPSILON: depth_eps_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        new_reg       <= new_next;
        rd_index_reg  <= rd_index_next;
        scan_idx_reg  <= scan_idx_next;
        idx_reg       <= idx_next;
        have_min_reg  <= have_min_next;
        min_depth_reg <= min_depth_next;
        if (load_out) begin
            m_tdata_reg <= {7'd0, res_entry, 5'(count_next), res_slot};
            m_tuser_reg <= res_acc;
        end
    end

    // entry store, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[idx_reg[AW-1:0]] <= new_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `CSDR_ASSERT(a_count_bound, aclk, aresetn, int'(count_reg) <= MAX_ENTRIES, "count over depth")
    `CSDR_ASSERT(a_scan_in_range, aclk, aresetn, (state_reg != S_SCAN) || (scan_idx_reg < count_reg), "scan past count")
    `CSDR_ASSERT_NEXT(a_offer_path, aclk, aresetn, in_acc && (s_cmd == CMD_OFFER), (state_reg == S_SCAN) || (state_reg == S_WRITE), "offer not scanned")
    `CSDR_ASSERT(a_stored_count, aclk, aresetn, !(m_valid_reg && m_tuser_reg) || (count_reg != '0), "stored beat with empty table")

endmodule

// ===== hdl/csdr_cmp.sv =====
// Shared compare unit: tests one stored entry against the offered contact.
// Depends on csdr_pkg.
`timescale 1ns / 1ps

module csdr_cmp (
    input  csdr_pkg::entry_t   new_entry,
    input  csdr_pkg::entry_t   stored,
    input  logic [15:0]        pos_eps,
    input  logic [15:0]        depth_eps,
    input  logic [30:0]        min_depth,
    output csdr_pkg::cmp_res_t res
);
    import csdr_pkg::*;

    function automatic logic near_axis(logic [31:0] a, logic [31:0] b, logic [15:0] eps);
        logic signed [32:0] d;
        logic [32:0]        mag;
        d = $signed({a[31], a}) - $signed({b[31], b});
        mag = d[32] ? 33'(-d) : 33'(d);
        return mag < {17'd0, eps};
    endfunction

    logic [31:0] depth_sum;

    assign depth_sum = {1'b0, stored.depth} + {16'd0, depth_eps};

    assign res.match = near_axis(new_entry.px, stored.px, pos_eps)
                     && near_axis(new_entry.py, stored.py, pos_eps)
                     && near_axis(new_entry.pz, stored.pz, pos_eps);
    assign res.deeper    = depth_sum < {1'b0, new_entry.depth};
    assign res.shallower = stored.depth < new_entry.depth;
    assign res.below_min = stored.depth < min_depth;

endmodule

// ===== dv/csdr_checker.sv =====
`timescale 1ns / 1ps
// Checker for the contact point table: watches the command, result and register
// channels, keeps its own copy of the table and compares every result beat.
// Depends on csdr_pkg.

module csdr_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [csdr_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [csdr_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic [0:0]                       m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [csdr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csdr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               errors,
    output int                               pending
);
    import csdr_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed {
        logic       accepted;
        logic [3:0] slot;
        logic [4:0] count;
        entry_t     ent;
    } reply_t;

    reply_t      expected_replies[$];
    entry_t      stored[SLOTS];
    int          entry_count = 0;
    logic [4:0]  slot_limit = 5'd16;
    logic [15:0] pos_eps = 16'd7;
    logic [15:0] depth_eps = 16'd7;
    int          err_tally = 0;

    function automatic bit within_tol(input logic signed [31:0] a, input logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return d < longint'(pos_eps);
    endfunction

    task automatic apply_command(input cmd_t cmd, input entry_t c, input logic [3:0] ridx,
                                 output reply_t r);
        int          limit;
        int          idx;
        int          k;
        bit          have_min;
        bit          hit;
        logic [30:0] min_depth;
        limit = (slot_limit < 1) ? 1 : (slot_limit > SLOTS) ? SLOTS : int'(slot_limit);
        r = '0;
        case (cmd)
            CMD_CLEAR: begin
                entry_count = 0;
            end
            CMD_OFFER: begin
                idx = entry_count;
                have_min = 1'b0;
                hit = 1'b0;
                min_depth = '0;
                for (k = 0; k < entry_count && !hit; k++) begin
                    if (within_tol(c.px, stored[k].px) && within_tol(c.py, stored[k].py) &&
                        within_tol(c.pz, stored[k].pz)) begin
                        hit = 1'b1;
                        idx = (longint'(stored[k].depth) + longint'(depth_eps) <
                               longint'(c.depth)) ? k : limit;
                    end else if (entry_count == limit &&
                                 (!have_min || stored[k].depth < min_depth) &&
                                 stored[k].depth < c.depth) begin
                        have_min = 1'b1;
                        min_depth = stored[k].depth;
                        idx = k;
                    end
                end
                if (idx < limit) begin
                    stored[idx] = c;
                    if (idx == entry_count)
                        entry_count++;
                    r.accepted = 1'b1;
                    r.slot = idx[3:0];
                end
            end
            CMD_READ: begin
                r.slot = ridx;
                if (ridx < entry_count)
                    r.ent = stored[ridx];
            end
            default: ;
        endcase
        r.count = entry_count[4:0];
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_tally++;
        end
    endtask

    always @(posedge aclk) begin
        reply_t want;
        entry_t got_ent;
        if (!aresetn) begin
            entry_count = 0;
            slot_limit = 5'd16;
            pos_eps = 16'd7;
            depth_eps = 16'd7;
            expected_replies.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SLOT_LIMIT:    slot_limit = cfg_data[4:0];
                    CFG_POS_EPSILON:   pos_eps = cfg_data;
                    CFG_DEPTH_EPSILON: depth_eps = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                apply_command(cmd_t'(s_tuser), s_tdata[191:0], s_tdata[195:192], want);
                expected_replies.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    $error("result beat with no command outstanding");
                    err_tally++;
                end else begin
                    want = expected_replies.pop_front();
                    got_ent = m_tdata[200:9];
                    cmp_field("accepted", want.accepted, m_tuser[0]);
                    cmp_field("slot", want.slot, m_tdata[3:0]);
                    cmp_field("count", want.count, m_tdata[8:4]);
                    cmp_field("out_pos_x", want.ent.px, got_ent.px);
                    cmp_field("out_pos_y", want.ent.py, got_ent.py);
                    cmp_field("out_pos_z", want.ent.pz, got_ent.pz);
                    cmp_field("read_depth", want.ent.depth, got_ent.depth);
                    cmp_field("out_normal_x", want.ent.nx, got_ent.nx);
                    cmp_field("out_normal_y", want.ent.ny, got_ent.ny);
                    cmp_field("out_normal_z", want.ent.nz, got_ent.nz);
                    cmp_field("out_side", want.ent.side, got_ent.side);
                end
            end
        end
        errors  <= err_tally;
        pending <= expected_replies.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for contact_set_dedup_replace: reset, directed and random command
// beats, register phases and randomised back-pressure; verdict from csdr_checker.
// Depends on csdr_pkg, csdr_checker and the RTL.

module tb;
    import csdr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 175;
    localparam int RECENT        = 8;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int     errors;
    int     pending;
    int     cycle_count = 0;
    bit     quiet = 1'b0;
    bit     hold_req = 1'b0;
    int     cur_pos_eps = 7;
    int     cur_depth_eps = 7;
    entry_t recent[RECENT];
    int     recent_wr = 0;

    always #5 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    contact_set_dedup_replace #(
        .MAX_ENTRIES(16)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    csdr_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic entry_t mk_contact(input logic [31:0] px, input logic [31:0] py,
                                          input logic [31:0] pz, input logic [30:0] d,
                                          input logic [15:0] nx, input logic [15:0] ny,
                                          input logic [15:0] nz, input logic [16:0] sd);
        entry_t c;
        c.px = px;
        c.py = py;
        c.pz = pz;
        c.depth = d;
        c.nx = nx;
        c.ny = ny;
        c.nz = nz;
        c.side = sd;
        return c;
    endfunction

    function automatic logic [31:0] nudge(input logic [31:0] v, input int span);
        return v + $urandom_range(0, 2 * span + 2) - (span + 1);
    endfunction

    task automatic send_beat(input cmd_t cmd, input entry_t c, input logic [3:0] ridx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, ridx, c};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic configure(input logic [4:0] mc, input logic [15:0] pe, input logic [15:0] de);
        write_reg(CFG_SLOT_LIMIT, {11'b0, mc});
        write_reg(CFG_POS_EPSILON, pe);
        write_reg(CFG_DEPTH_EPSILON, de);
        cfg_valid <= 1'b0;
        cur_pos_eps = int'(pe);
        cur_depth_eps = int'(de);
    endtask

    task automatic send_random_item();
        int         r;
        cmd_t       cmd;
        entry_t     c;
        entry_t     base;
        logic [3:0] ridx;
        longint     v;
        if ($urandom_range(0, 59) == 0)
            quiet = !quiet;
        r = $urandom_range(0, 99);
        cmd = (r < 62) ? CMD_OFFER : (r < 92) ? CMD_READ : (r < 96) ? CMD_CLEAR : CMD_NOP;
        c.nx = 16'($urandom);
        c.ny = 16'($urandom);
        c.nz = 16'($urandom);
        c.side = ($urandom_range(0, 7) == 0) ? 17'h1FFFF : 17'($urandom_range(0, 65535));
        ridx = 4'($urandom);
        base = recent[$urandom_range(0, RECENT - 1)];
        r = $urandom_range(0, 99);
        if (r < 60) begin
            c.px = nudge(base.px, cur_pos_eps);
            c.py = nudge(base.py, cur_pos_eps);
            c.pz = nudge(base.pz, cur_pos_eps);
        end else if (r < 85) begin
            c.px = $urandom_range(0, 10000) - 5000;
            c.py = $urandom_range(0, 10000) - 5000;
            c.pz = $urandom_range(0, 10000) - 5000;
        end else begin
            c.px = $urandom;
            c.py = $urandom;
            c.pz = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 35) begin
            v = longint'(base.depth) + longint'($urandom_range(0, 2 * cur_depth_eps + 2))
                - longint'(cur_depth_eps + 1);
            if (v < 0)
                v = 0;
            if (v > 64'h7FFF_FFFF)
                v = 64'h7FFF_FFFF;
            c.depth = v[30:0];
        end else if (r < 80) begin
            c.depth = 31'($urandom_range(0, 4000));
        end else if (r < 95) begin
            c.depth = 31'($urandom);
        end else begin
            c.depth = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
        end
        if (cmd == CMD_OFFER) begin
            recent[recent_wr] = c;
            recent_wr = (recent_wr + 1) % RECENT;
        end
        send_beat(cmd, c, ridx);
    endtask

    // result side: random ready/stall runs, long hold on request
    initial begin
        int run;
        bit rdy;
        run = 0;
        rdy = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (run == 0) begin
                if (hold_req) begin
                    hold_req = 1'b0;
                    rdy = 1'b0;
                    run = LONG_HOLD;
                end else if (!rdy) begin
                    rdy = 1'b1;
                    run = $urandom_range(1, 16);
                end else begin
                    run = pick_gap();
                    if (run == 0)
                        run = $urandom_range(1, 16);
                    else
                        rdy = 1'b0;
                end
            end
            m_tready <= rdy;
            run--;
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [4:0]  phase_max [RANDOM_PHASES];
        logic [15:0] phase_pe  [RANDOM_PHASES];
        logic [15:0] phase_de  [RANDOM_PHASES];
        int          n;
        phase_max = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd8, 5'd16, 5'd3};
        phase_pe  = '{16'd7, 16'd65535, 16'd0, 16'd300, 16'd1, 16'd2000, 16'd40, 16'd65535};
        phase_de  = '{16'd7, 16'd0, 16'd65535, 16'd100, 16'd0, 16'd1, 16'd500, 16'd65535};
        for (int i = 0; i < RECENT; i++)
            recent[i] = '0;
        n = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty read, duplicate reject/overwrite, edge of tolerance, extremes
        send_beat(CMD_READ, '0, 4'd0);
        send_beat(CMD_OFFER, mk_contact(0, 0, 0, 100, 16'h4000, 0, 0, 17'd5), 4'd0);
        send_beat(CMD_OFFER, mk_contact(6, -32'd6, 6, 106, 0, 16'h4000, 0, 17'd6), 4'd0);
        send_beat(CMD_OFFER, mk_contact(6, 0, -32'd6, 108, 0, 0, 16'h4000, 17'd7), 4'd0);
        send_beat(CMD_OFFER, mk_contact(13, 0, 0, 50, 16'hC000, 0, 0, 17'd8), 4'd0);
        send_beat(CMD_OFFER, mk_contact(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        31'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                        17'h1FFFF), 4'd0);
        send_beat(CMD_OFFER, mk_contact(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
                                        16'h8000, 16'h8000, 16'h8000, 17'h0FFFF), 4'd0);
        send_beat(CMD_READ, '0, 4'd0);
        send_beat(CMD_READ, '0, 4'd1);
        send_beat(CMD_READ, '0, 4'd2);
        send_beat(CMD_READ, '0, 4'd3);
        send_beat(CMD_READ, '0, 4'd4);
        send_beat(CMD_READ, '0, 4'd15);
        send_beat(CMD_NOP, mk_contact(1, 2, 3, 4, 5, 6, 7, 8), 4'd15);
        send_beat(CMD_CLEAR, '0, 4'd0);
        send_beat(CMD_READ, '0, 4'd0);
        drain();

        // two slots: replace the shallowest, reject when none is shallower
        configure(5'd2, 16'd7, 16'd7);
        send_beat(CMD_OFFER, mk_contact(1000, 1000, 1000, 10, 1, 1, 1, 17'd1), 4'd0);
        send_beat(CMD_OFFER, mk_contact(2000, 2000, 2000, 20, 2, 2, 2, 17'd2), 4'd0);
        send_beat(CMD_OFFER, mk_contact(3000, 3000, 3000, 15, 3, 3, 3, 17'd3), 4'd0);
        send_beat(CMD_OFFER, mk_contact(4000, 4000, 4000, 5, 4, 4, 4, 17'd4), 4'd0);
        drain();

        // limit below count: no append, no overwrite at or above the limit
        configure(5'd1, 16'd7, 16'd7);
        send_beat(CMD_OFFER, mk_contact(5000, 5000, 5000, 500, 5, 5, 5, 17'd5), 4'd0);
        send_beat(CMD_OFFER, mk_contact(2001, 2001, 2001, 100, 6, 6, 6, 17'd6), 4'd0);
        send_beat(CMD_OFFER, mk_contact(3001, 3001, 3001, 100, 7, 7, 7, 17'd7), 4'd0);
        drain();

        // zero tolerance never matches
        configure(5'd1, 16'd0, 16'd65535);
        send_beat(CMD_OFFER, mk_contact(3001, 3001, 3001, 1000, 8, 8, 8, 17'd8), 4'd0);
        send_beat(CMD_READ, '0, 4'd0);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 6)
                configure(5'($urandom_range(2, 15)), 16'($urandom_range(1, 3000)),
                          16'($urandom_range(0, 3000)));
            else
                configure(phase_max[ph], phase_pe[ph], phase_de[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (n == 250 || n == 900)
                    hold_req = 1'b1;
                send_random_item();
                n++;
            end
            drain();
        end

        repeat (40) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/csdr_pkg.sv
hdl/csdr_cmp.sv
hdl/contact_set_dedup_replace.sv
dv/csdr_checker.sv
dv/tb.sv
